// ===== rtl/tkf_pkg.sv =====
// Shared types, constants and helpers for the two-axis tilt fusion core.
package tkf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int COV_FRAC_BITS   = 30;
  localparam int CFG_W           = 31;
  localparam int PROD_W          = 72;
  localparam int OPND_W          = 36;

  // Complementary filter weights, 16 fraction bits
  localparam logic signed [OPND_W-1:0] COMP_GYRO_W = 36'sd60948;
  localparam logic signed [OPND_W-1:0] COMP_ACC_W  = 36'sd4588;

  localparam logic signed [PROD_W-1:0] LIM_90  = PROD_W'(90)  <<< ANGLE_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] LIM_180 = PROD_W'(180) <<< ANGLE_FRAC_BITS;

  // Register reset values
  localparam logic [CFG_W-1:0] Q_ANGLE_RST = 31'd1073742;
  localparam logic [CFG_W-1:0] Q_BIAS_RST  = 31'd3221225;
  localparam logic [CFG_W-1:0] R_MEAS_RST  = 31'd32212255;

  // Register indexes
  localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
  localparam logic [1:0] CFG_Q_BIAS  = 2'd1;
  localparam logic [1:0] CFG_R_MEAS  = 2'd2;

  localparam logic REQ_UPDATE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] roll_meas;
    logic [31:0] pitch_meas;
    logic [31:0] rate_x;
    logic [31:0] rate_y;
    logic [15:0] step_time;
  } tkf_in_t;

  typedef struct packed {
    logic [31:0] kalman_roll;
    logic [31:0] kalman_pitch;
    logic [31:0] comp_roll;
    logic [31:0] comp_pitch;
    logic [31:0] gyro_roll;
    logic [31:0] gyro_pitch;
  } tkf_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESTART, S_START, S_PITCH,
    S_K_UNB, S_K_ANG, S_K_D1, S_K_P00, S_K_P11,
    S_K_DIV0, S_K_DIV, S_K_KSTORE,
    S_K_Y, S_K_E1, S_K_E2, S_K_CAA, S_K_CAB, S_K_CBA, S_K_CBB,
    S_SP_MUL, S_SP_G, S_SP_C1, S_SP_C2, S_OUT
  } tkf_state_t;

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (x > PROD_W'(64'sh7FFF_FFFF))
      r = 32'sh7FFF_FFFF;
    else if (x < -PROD_W'(64'sh8000_0000))
      r = 32'sh8000_0000;
    else
      r = x[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/two_axis_kalman_tilt_fusion_core.sv =====
// Two-axis tilt fusion: Kalman, complementary and gyro angles for roll and pitch.
//
// Input channel (in_valid / in_stall / in_data): one request per IMU sample.
// req_type update runs both Kalman filters, the complementary filters and
// the gyro integrators; req_type restart loads the start angles and clears
// bias, covariance and the Kalman outputs.
// Output channel (out_valid / out_stall / out_data): one result per request.
// Configuration: cfg_we / cfg_addr / cfg_data write the noise registers;
// write them only while no request is in flight.
//
// All multiplications go through one shared 36x36 multiplier and the gain
// divisions through one radix-2 divider, under a sequencer. An update runs a
// start step, the roll filter, an axis switch, the pitch filter and the
// side paths; each filter does two gain divisions (32 quotient bits plus
// setup and store) and ten multiply steps. A roll jump across +-90 skips the
// roll filter; a zero innovation variance skips that axis's two divisions.
// in_stall is high from acceptance until the result is taken, so one request
// is in the block. Reset (rst, synchronous) clears all filter state and loads
// the default noise registers. A stalled result holds on out_data until taken.
module two_axis_kalman_tilt_fusion_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tkf_pkg::tkf_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tkf_pkg::tkf_out_t out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [30:0]     cfg_data
);
  import tkf_pkg::*;

  tkf_state_t state, state_next;

  logic [CFG_W-1:0] q_angle, q_bias, r_meas;
  tkf_in_t req;

  logic signed [31:0] ea [2];
  logic signed [31:0] eb [2];
  logic signed [31:0] caa [2];
  logic signed [31:0] cab [2];
  logic signed [31:0] cba [2];
  logic signed [31:0] cbb [2];
  logic signed [31:0] fa [2];
  logic signed [31:0] ca [2];
  logic signed [31:0] ia [2];

  logic ax;
  logic signed [32:0] rate_p;
  logic signed [31:0] p00, p01, p10, p11, k0, k1, yr;
  logic signed [PROD_W-1:0] prod, tmp;
  logic signed [OPND_W-1:0] mul_a, mul_b;

  // Divider
  logic        dsel, dneg, dovf;
  logic [33:0] drem;
  logic [31:0] dlo, dq;
  logic [4:0]  dcnt;

  // Working values
  logic signed [PROD_W-1:0] t_x, rate_x, rate_cur, meas_cur, sh16, sh30, d1, inner;
  logic signed [PROD_W-1:0] s_x, num_x, ax_ang, x_x, g_x;
  logic signed [31:0] unb, y_c, g_s;
  logic [61:0] mag_n;
  logic [32:0] mag_s;
  logic [34:0] r2;
  logic signed [PROD_W-1:0] qv;
  logic jump, roll_out;

  always_comb begin
    t_x      = PROD_W'($signed({1'b0, req.step_time}));
    rate_x   = PROD_W'($signed(req.rate_x));
    rate_cur = ax ? PROD_W'(rate_p) : rate_x;
    meas_cur = ax ? PROD_W'($signed(req.pitch_meas)) : PROD_W'($signed(req.roll_meas));
    sh16     = prod >>> 16;
    sh30     = prod >>> COV_FRAC_BITS;
    d1       = sh16;
    inner    = d1 - PROD_W'(cab[ax]) - PROD_W'(cba[ax])
               + PROD_W'($signed({1'b0, q_angle}) >>> (30 - COV_FRAC_BITS));
    unb      = sat32(rate_cur - PROD_W'(eb[ax]));
    y_c      = sat32(meas_cur - PROD_W'(ea[ax]));
    s_x      = PROD_W'(p00) + PROD_W'($signed({1'b0, r_meas}) >>> (30 - COV_FRAC_BITS));
    num_x    = (dsel ? PROD_W'(p10) : PROD_W'(p00)) <<< COV_FRAC_BITS;
    mag_n    = num_x[PROD_W-1] ? 62'(-num_x) : 62'(num_x);
    mag_s    = s_x[PROD_W-1] ? 33'(-s_x) : 33'(s_x);
    r2       = {drem[33:0], dlo[31]};
    qv       = dneg ? -PROD_W'({1'b0, dq}) : PROD_W'({1'b0, dq});
    ax_ang   = PROD_W'(fa[0]);
    jump     = ($signed(req.roll_meas) < $signed(-LIM_90[31:0]) && ax_ang > LIM_90) ||
               ($signed(req.roll_meas) > $signed(LIM_90[31:0]) && ax_ang < -LIM_90);
    roll_out = (ax_ang > LIM_90) || (ax_ang < -LIM_90);
    x_x      = PROD_W'(ca[ax]) + sh16;
    g_s      = sat32(PROD_W'(ia[ax]) + sh16);
    g_x      = PROD_W'(g_s);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = (in_data.req_type == REQ_RESTART) ? S_RESTART : S_START;
      S_RESTART:  state_next = S_OUT;
      S_START:    state_next = jump ? S_PITCH : S_K_UNB;
      S_PITCH:    state_next = S_K_UNB;
      S_K_UNB:    state_next = S_K_ANG;
      S_K_ANG:    state_next = S_K_D1;
      S_K_D1:     state_next = S_K_P00;
      S_K_P00:    state_next = S_K_P11;
      S_K_P11:    state_next = (s_x == '0) ? S_K_Y : S_K_DIV0;
      S_K_DIV0:   state_next = S_K_DIV;
      S_K_DIV:    if (dcnt == 5'd31) state_next = S_K_KSTORE;
      S_K_KSTORE: state_next = dsel ? S_K_Y : S_K_DIV0;
      S_K_Y:      state_next = S_K_E1;
      S_K_E1:     state_next = S_K_E2;
      S_K_E2:     state_next = S_K_CAA;
      S_K_CAA:    state_next = S_K_CAB;
      S_K_CAB:    state_next = S_K_CBA;
      S_K_CBA:    state_next = S_K_CBB;
      S_K_CBB:    state_next = ax ? S_SP_MUL : S_PITCH;
      S_SP_MUL:   state_next = S_SP_G;
      S_SP_G:     state_next = S_SP_C1;
      S_SP_C1:    state_next = S_SP_C2;
      S_SP_C2:    state_next = ax ? S_OUT : S_SP_MUL;
      S_OUT:      if (!out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Handshake and multiplier operand select
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_OUT);
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_K_UNB: begin mul_a = t_x[OPND_W-1:0]; mul_b = OPND_W'(unb); end
      S_K_ANG: begin mul_a = t_x[OPND_W-1:0]; mul_b = OPND_W'(cbb[ax]); end
      S_K_D1:  begin mul_a = t_x[OPND_W-1:0]; mul_b = inner[OPND_W-1:0]; end
      S_K_P00: begin
        mul_a = t_x[OPND_W-1:0];
        mul_b = OPND_W'($signed({1'b0, q_bias}) >>> (30 - COV_FRAC_BITS));
      end
      S_K_Y:   begin mul_a = OPND_W'(k0); mul_b = OPND_W'(y_c); end
      S_K_E1:  begin mul_a = OPND_W'(k1); mul_b = OPND_W'(yr); end
      S_K_E2:  begin mul_a = OPND_W'(k0); mul_b = OPND_W'(p00); end
      S_K_CAA: begin mul_a = OPND_W'(k0); mul_b = OPND_W'(p01); end
      S_K_CAB: begin mul_a = OPND_W'(k1); mul_b = OPND_W'(p00); end
      S_K_CBA: begin mul_a = OPND_W'(k1); mul_b = OPND_W'(p01); end
      S_SP_MUL: begin mul_a = rate_cur[OPND_W-1:0]; mul_b = t_x[OPND_W-1:0]; end
      S_SP_G:  begin mul_a = COMP_GYRO_W; mul_b = x_x[OPND_W-1:0]; end
      S_SP_C1: begin mul_a = COMP_ACC_W; mul_b = meas_cur[OPND_W-1:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      q_angle <= Q_ANGLE_RST;
      q_bias  <= Q_BIAS_RST;
      r_meas  <= R_MEAS_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_Q_ANGLE: q_angle <= cfg_data;
          CFG_Q_BIAS:  q_bias  <= cfg_data;
          CFG_R_MEAS:  r_meas  <= cfg_data;
          default:     ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a * mul_b);
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        ea[i] <= '0; eb[i] <= '0; caa[i] <= '0; cab[i] <= '0;
        cba[i] <= '0; cbb[i] <= '0; fa[i] <= '0; ca[i] <= '0; ia[i] <= '0;
      end
      ax <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) req <= in_data;
          ax <= 1'b0;
        end
        S_RESTART: begin
          ea[0] <= $signed(req.roll_meas);  ea[1] <= $signed(req.pitch_meas);
          ca[0] <= $signed(req.roll_meas);  ca[1] <= $signed(req.pitch_meas);
          ia[0] <= $signed(req.roll_meas);  ia[1] <= $signed(req.pitch_meas);
          for (int i = 0; i < 2; i++) begin
            eb[i] <= '0; caa[i] <= '0; cab[i] <= '0; cba[i] <= '0; cbb[i] <= '0;
            fa[i] <= '0;
          end
        end
        S_START: begin
          // roll jumped across +-90: snap roll to the measurement
          if (jump) begin
            ea[0] <= $signed(req.roll_meas);
            fa[0] <= $signed(req.roll_meas);
            ca[0] <= $signed(req.roll_meas);
            ia[0] <= $signed(req.roll_meas);
          end
        end
        S_PITCH: begin
          ax     <= 1'b1;
          rate_p <= roll_out ? -33'($signed(req.rate_y)) : 33'($signed(req.rate_y));
        end
        S_K_ANG: ea[ax] <= sat32(PROD_W'(ea[ax]) + sh16);
        S_K_D1: begin
          p01 <= sat32(PROD_W'(cab[ax]) - d1);
          p10 <= sat32(PROD_W'(cba[ax]) - d1);
        end
        S_K_P00: p00 <= sat32(PROD_W'(caa[ax]) + sh16);
        S_K_P11: begin
          p11  <= sat32(PROD_W'(cbb[ax]) + sh16);
          dsel <= 1'b0;
          k0   <= '0;
          k1   <= '0;
        end
        S_K_DIV0: begin
          dneg <= num_x[PROD_W-1] ^ s_x[PROD_W-1];
          dovf <= ({4'b0, mag_n[61:32]} >= mag_s);
          drem <= {4'b0, mag_n[61:32]};
          dlo  <= mag_n[31:0];
          dq   <= '0;
          dcnt <= '0;
        end
        S_K_DIV: begin
          // one quotient bit per cycle
          if (r2 >= {2'b0, mag_s}) begin
            drem <= 34'(r2 - {2'b0, mag_s});
            dq   <= {dq[30:0], 1'b1};
          end else begin
            drem <= r2[33:0];
            dq   <= {dq[30:0], 1'b0};
          end
          dlo  <= {dlo[30:0], 1'b0};
          dcnt <= dcnt + 5'd1;
        end
        S_K_KSTORE: begin
          if (dsel) k1 <= dovf ? (dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sat32(qv);
          else      k0 <= dovf ? (dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sat32(qv);
          dsel <= 1'b1;
        end
        S_K_Y:   yr <= y_c;
        S_K_E1:  ea[ax] <= sat32(PROD_W'(ea[ax]) + sh30);
        S_K_E2:  eb[ax] <= sat32(PROD_W'(eb[ax]) + sh30);
        S_K_CAA: caa[ax] <= sat32(PROD_W'(p00) - sh30);
        S_K_CAB: cab[ax] <= sat32(PROD_W'(p01) - sh30);
        S_K_CBA: cba[ax] <= sat32(PROD_W'(p10) - sh30);
        S_K_CBB: begin
          cbb[ax] <= sat32(PROD_W'(p11) - sh30);
          fa[ax]  <= ea[ax];
          if (ax) ax <= 1'b0;
        end
        S_SP_G: begin
          // gyro angle falls back to the Kalman angle past +-180
          ia[ax] <= (g_x < -LIM_180 || g_x > LIM_180) ? fa[ax] : g_s;
        end
        S_SP_C1: tmp <= prod;
        S_SP_C2: begin
          ca[ax] <= sat32((tmp + prod) >>> 16);
          ax     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_data.kalman_roll  = fa[0];
  assign out_data.kalman_pitch = fa[1];
  assign out_data.comp_roll    = ca[0];
  assign out_data.comp_pitch   = ca[1];
  assign out_data.gyro_roll    = ia[0];
  assign out_data.gyro_pitch   = ia[1];

endmodule

// ===== rtl/tkf_checker.sv =====
// Port-level checks for the tilt fusion core, bound to the top level.
module tkf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tkf_pkg::tkf_out_t out_data
);
  import tkf_pkg::*;

  // a pending result blocks new requests
  a_busy_when_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");

  // an accepted request keeps the input closed next cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("input not closed after accept");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result right after reset");

endmodule

bind two_axis_kalman_tilt_fusion_core tkf_checker u_tkf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/tb_two_axis_kalman_tilt_fusion_core.sv =====
// Self-checking testbench for the two-axis Kalman tilt fusion core.
`timescale 1ns / 1ps

module tb_two_axis_kalman_tilt_fusion_core;
  import tkf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tkf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tkf_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_Q_ANGLE;
  logic [30:0] cfg_data = '0;

  two_axis_kalman_tilt_fusion_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted tilt state, one entry per axis (0 roll, 1 pitch)
  longint tilt_angle [2];
  longint tilt_bias  [2];
  longint tilt_paa [2], tilt_pab [2], tilt_pba [2], tilt_pbb [2];
  longint tilt_fused [2];
  longint tilt_comp  [2];
  longint tilt_gyro  [2];
  longint noise_angle, noise_bias, noise_meas;

  tkf_out_t expected_angles [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;

  function automatic longint shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic void reset_tilt();
    for (int i = 0; i < 2; i++) begin
      tilt_angle[i] = 0; tilt_bias[i] = 0;
      tilt_paa[i] = 0; tilt_pab[i] = 0; tilt_pba[i] = 0; tilt_pbb[i] = 0;
      tilt_fused[i] = 0; tilt_comp[i] = 0; tilt_gyro[i] = 0;
    end
    noise_angle = Q_ANGLE_RST;
    noise_bias  = Q_BIAS_RST;
    noise_meas  = R_MEAS_RST;
  endfunction

  // One Kalman predict/update step on one axis
  function automatic void kalman_axis(int ax, longint meas, longint rate, longint dt);
    longint unb, p00, p01, p10, p11, s, k0, k1, y, inner, d1;
    k0 = 0; k1 = 0;
    unb = clip32(rate - tilt_bias[ax]);
    tilt_angle[ax] = clip32(tilt_angle[ax] + shr(dt * unb, 16));
    p00 = tilt_paa[ax]; p01 = tilt_pab[ax]; p10 = tilt_pba[ax]; p11 = tilt_pbb[ax];
    d1 = shr(dt * p11, 16);
    inner = d1 - p01 - p10 + noise_angle;
    p00 = clip32(p00 + shr(dt * inner, 16));
    p01 = clip32(p01 - d1);
    p10 = clip32(p10 - d1);
    p11 = clip32(p11 + shr(noise_bias * dt, 16));
    s = p00 + noise_meas;
    if (s != 0) begin
      // C division truncates toward zero, as does SV
      k0 = clip32((p00 <<< COV_FRAC_BITS) / s);
      k1 = clip32((p10 <<< COV_FRAC_BITS) / s);
    end
    y = clip32(meas - tilt_angle[ax]);
    tilt_angle[ax] = clip32(tilt_angle[ax] + shr(k0 * y, COV_FRAC_BITS));
    tilt_bias[ax]  = clip32(tilt_bias[ax] + shr(k1 * y, COV_FRAC_BITS));
    tilt_paa[ax] = clip32(p00 - shr(k0 * p00, COV_FRAC_BITS));
    tilt_pab[ax] = clip32(p01 - shr(k0 * p01, COV_FRAC_BITS));
    tilt_pba[ax] = clip32(p10 - shr(k1 * p00, COV_FRAC_BITS));
    tilt_pbb[ax] = clip32(p11 - shr(k1 * p01, COV_FRAC_BITS));
    tilt_fused[ax] = tilt_angle[ax];
  endfunction

  // Complementary and raw gyro angles
  function automatic void side_axis(int ax, longint meas, longint rate, longint dt);
    longint lim, d, g, x;
    lim = 180 <<< ANGLE_FRAC_BITS;
    d = shr(rate * dt, 16);
    g = clip32(tilt_gyro[ax] + d);
    x = tilt_comp[ax] + d;
    tilt_comp[ax] = clip32(shr(60948 * x + 4588 * meas, 16));
    if (g < -lim || g > lim) g = tilt_fused[ax];
    tilt_gyro[ax] = g;
  endfunction

  function automatic tkf_out_t predict_tilt(tkf_in_t r);
    longint roll, pitch, rx, ry, dt, n90;
    tkf_out_t o;
    roll  = longint'($signed(r.roll_meas));
    pitch = longint'($signed(r.pitch_meas));
    rx = longint'($signed(r.rate_x));
    ry = longint'($signed(r.rate_y));
    dt = longint'(r.step_time);
    n90 = 90 <<< ANGLE_FRAC_BITS;
    if (r.req_type == REQ_RESTART) begin
      for (int i = 0; i < 2; i++) begin
        tilt_angle[i] = (i == 0) ? roll : pitch;
        tilt_bias[i] = 0;
        tilt_paa[i] = 0; tilt_pab[i] = 0; tilt_pba[i] = 0; tilt_pbb[i] = 0;
        tilt_fused[i] = 0;
        tilt_comp[i] = tilt_angle[i];
        tilt_gyro[i] = tilt_angle[i];
      end
    end else begin
      // roll wrap across +-90 restarts the roll angles from the measurement
      if ((roll < -n90 && tilt_fused[0] > n90) || (roll > n90 && tilt_fused[0] < -n90)) begin
        tilt_angle[0] = roll; tilt_comp[0] = roll;
        tilt_fused[0] = roll; tilt_gyro[0] = roll;
      end else begin
        kalman_axis(0, roll, rx, dt);
      end
      if (tilt_fused[0] > n90 || tilt_fused[0] < -n90) ry = -ry;
      kalman_axis(1, pitch, ry, dt);
      side_axis(0, roll, rx, dt);
      side_axis(1, pitch, ry, dt);
    end
    o.kalman_roll  = tilt_fused[0][31:0];
    o.kalman_pitch = tilt_fused[1][31:0];
    o.comp_roll    = tilt_comp[0][31:0];
    o.comp_pitch   = tilt_comp[1][31:0];
    o.gyro_roll    = tilt_gyro[0][31:0];
    o.gyro_pitch   = tilt_gyro[1][31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    tkf_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected result", out_data.kalman_roll, '0);
      end else begin
        want = expected_angles.pop_front();
        if (out_data.kalman_roll != want.kalman_roll)
          report_mismatch("kalman_roll", out_data.kalman_roll, want.kalman_roll);
        if (out_data.kalman_pitch != want.kalman_pitch)
          report_mismatch("kalman_pitch", out_data.kalman_pitch, want.kalman_pitch);
        if (out_data.comp_roll != want.comp_roll)
          report_mismatch("comp_roll", out_data.comp_roll, want.comp_roll);
        if (out_data.comp_pitch != want.comp_pitch)
          report_mismatch("comp_pitch", out_data.comp_pitch, want.comp_pitch);
        if (out_data.gyro_roll != want.gyro_roll)
          report_mismatch("gyro_roll", out_data.gyro_roll, want.gyro_roll);
        if (out_data.gyro_pitch != want.gyro_pitch)
          report_mismatch("gyro_pitch", out_data.gyro_pitch, want.gyro_pitch);
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one request; valid stays high until accepted
  task automatic send_request(tkf_in_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_angles.push_back(predict_tilt(r));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_angles.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, only while idle
  task automatic write_noise(logic [1:0] idx, logic [30:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_Q_ANGLE: noise_angle = val;
      CFG_Q_BIAS:  noise_bias  = val;
      CFG_R_MEAS:  noise_meas  = val;
      default: ;
    endcase
  endtask

  function automatic tkf_in_t make_request(logic kind, longint roll, longint pitch,
                                           longint rx, longint ry, int dt);
    tkf_in_t r;
    r.req_type = kind;
    r.roll_meas = roll[31:0]; r.pitch_meas = pitch[31:0];
    r.rate_x = rx[31:0]; r.rate_y = ry[31:0];
    r.step_time = dt[15:0];
    return r;
  endfunction

  // Realistic angle in degrees, Q16
  function automatic longint rand_angle(int deg);
    return longint'($signed($urandom_range(2 * deg * 65536))) - deg * 65536;
  endfunction

  function automatic tkf_in_t rand_request();
    tkf_in_t r;
    int pick;
    logic [191:0] noise_bits;
    pick = $urandom_range(99);
    if (pick < 4) begin
      r = make_request(REQ_RESTART, rand_angle(180), rand_angle(90), 0, 0, 0);
    end else if (pick < 14) begin
      // full-range noise
      noise_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise_bits[$bits(tkf_in_t)-1:0];
      r.req_type = REQ_UPDATE;
    end else if (pick < 24) begin
      // roll flip across +-90
      r = make_request(REQ_UPDATE, ($urandom_range(1) ? 1 : -1) * (170 <<< 16) + rand_angle(9),
                       rand_angle(80), rand_angle(300), rand_angle(300),
                       $urandom_range(100, 3000));
    end else begin
      r = make_request(REQ_UPDATE, rand_angle(180), rand_angle(90), rand_angle(250),
                       rand_angle(250), $urandom_range(65, 2000));
    end
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(rand_request());
  endtask

  // Extremes, restart, roll flip and zero step
  task automatic test_directed();
    send_request(make_request(REQ_UPDATE, 10 <<< 16, -5 <<< 16, 1 <<< 16, -1 <<< 16, 655));
    send_request(make_request(REQ_RESTART, 45 <<< 16, -30 <<< 16, 0, 0, 0));
    send_request(make_request(REQ_UPDATE, 46 <<< 16, -29 <<< 16, 3 <<< 16, 2 <<< 16, 0));
    send_request(make_request(REQ_UPDATE, 2147483647, -2147483648, 2147483647,
                              -2147483648, 65535));
    send_request(make_request(REQ_UPDATE, -2147483648, 2147483647, -2147483648,
                              2147483647, 65535));
    send_request(make_request(REQ_RESTART, 170 <<< 16, 10 <<< 16, 0, 0, 0));
    send_request(make_request(REQ_UPDATE, 170 <<< 16, 10 <<< 16, 5 <<< 16, 5 <<< 16, 655));
    send_request(make_request(REQ_UPDATE, 170 <<< 16, 10 <<< 16, 5 <<< 16, 5 <<< 16, 655));
    // roll jumps from above +90 to below -90
    send_request(make_request(REQ_UPDATE, -170 <<< 16, 12 <<< 16, 5 <<< 16, 7 <<< 16, 655));
    send_request(make_request(REQ_UPDATE, 175 <<< 16, 12 <<< 16, 5 <<< 16, 7 <<< 16, 655));
    // gyro angle drifts past 180
    send_request(make_request(REQ_RESTART, 179 <<< 16, -179 <<< 16, 0, 0, 0));
    send_request(make_request(REQ_UPDATE, 179 <<< 16, -179 <<< 16, 100 <<< 16,
                              -100 <<< 16, 65535));
    send_request(make_request(REQ_RESTART, -1, -1, -1, -1, 65535));
    send_request(make_request(REQ_UPDATE, -1, -1, -1, -1, 65535));
    send_request(make_request(REQ_UPDATE, 0, 0, 0, 0, 1));
  endtask

  // Zero innovation variance and register extremes
  task automatic test_noise_settings();
    write_noise(CFG_R_MEAS, '0);
    write_noise(CFG_Q_ANGLE, '0);
    write_noise(CFG_Q_BIAS, '0);
    send_request(make_request(REQ_RESTART, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_UPDATE, 5 <<< 16, 5 <<< 16, 1 <<< 16, 1 <<< 16, 0));
    run_random(60);
    write_noise(CFG_Q_ANGLE, 31'h7FFF_FFFF);
    write_noise(CFG_Q_BIAS, 31'h7FFF_FFFF);
    write_noise(CFG_R_MEAS, 31'h7FFF_FFFF);
    run_random(120);
    write_noise(CFG_Q_ANGLE, 31'($urandom));
    write_noise(CFG_Q_BIAS, 31'($urandom));
    write_noise(CFG_R_MEAS, 31'($urandom_range(1, 31'h7FFF_FFFF)));
    run_random(120);
    write_noise(CFG_Q_ANGLE, Q_ANGLE_RST);
    write_noise(CFG_Q_BIAS, Q_BIAS_RST);
    write_noise(CFG_R_MEAS, R_MEAS_RST);
  endtask

  // Random traffic across the idling phases
  task automatic test_idling_phases();
    send_idle_pct = 0;  stall_pct = 0;  run_random(400);
    send_idle_pct = 75; stall_pct = 0;  run_random(250);
    // hold off until every pending result is back
    wait_drained();
    send_idle_pct = 0;  stall_pct = 75; run_random(250);
    send_idle_pct = 35; stall_pct = 35; run_random(400);
    send_idle_pct = 0;  stall_pct = 0;
  endtask

  initial begin
    reset_tilt();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_noise_settings();
    test_idling_phases();
    wait_drained();
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
